### rtl/ses_pkg.sv
// Shared types and constants for the segmented energy stack.
// No dependencies; used by every module under rtl/ except ses_ram.
package ses_pkg;

   localparam int VAL_W     = 10;
   localparam int STATUS_W  = 2;
   localparam int SEG_OUT_W = 8;

   localparam int STORE_DEPTH_DEF   = 256;
   localparam int SEGMENT_COUNT_DEF = 256;

   localparam logic [VAL_W-1:0] CAP_RESET = 10'd1000;

   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_POP_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_PUSH_FULL = 2'd2;

   // Controller to datapath commands.
   typedef struct packed {
      logic capture;   // latch request beat, launch RAM reads
      logic exec;      // RAM data valid: update state, register result
   } ctrl_cmd_type;

endpackage

### rtl/ses_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ses_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

### rtl/ses_ctrl.sv
// Controller for the segmented energy stack: idle / execute sequencing.
// Depends on ses_pkg.
module ses_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output ses_pkg::ctrl_cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   logic state_in;

   assign busy        = (state_ff != ST_IDLE);
   assign cmd.capture = start && (state_ff == ST_IDLE);
   assign cmd.exec    = (state_ff == ST_EXEC);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_exec_one_cycle: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> !cmd.exec)
      else $error("execute held for more than one cycle");

endmodule

### rtl/ses_dpath.sv
// Datapath: value store, segment sum store, top/segment/current-sum registers,
// capacity register and result registers. Depends on ses_pkg and ses_ram.
module ses_dpath #(
   parameter int STORE_DEPTH   = ses_pkg::STORE_DEPTH_DEF,
   parameter int SEGMENT_COUNT = ses_pkg::SEGMENT_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ses_pkg::ctrl_cmd_type           cmd,
   input  logic                            req_action,
   input  logic [ses_pkg::VAL_W-1:0]       req_energy_in,
   input  logic                            csr_wr_en,
   input  logic [ses_pkg::VAL_W-1:0]       csr_wr_data,
   output logic                            rsp_valid,
   output logic [ses_pkg::VAL_W-1:0]       rsp_energy_out,
   output logic [ses_pkg::STATUS_W-1:0]    rsp_status,
   output logic [ses_pkg::SEG_OUT_W-1:0]   rsp_segment_now,
   output logic [ses_pkg::VAL_W-1:0]       rsp_segment_total
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int TW = $clog2(STORE_DEPTH + 1);
   localparam int SW = $clog2(SEGMENT_COUNT);
   localparam int VW = ses_pkg::VAL_W;
   localparam int OW = ses_pkg::SEG_OUT_W;

   localparam logic [TW-1:0] TOP_FULL = TW'(STORE_DEPTH);
   localparam logic [SW-1:0] SEG_LAST = SW'(SEGMENT_COUNT - 1);

   // architectural state
   logic [VW-1:0] cap_ff;
   logic [TW-1:0] top_ff, top_in;
   logic [SW-1:0] seg_ff, seg_in;
   logic [VW-1:0] sum_ff, sum_in;   // sum of the current segment

   // captured request
   logic          act_ff;
   logic [VW-1:0] energy_ff;

   // result registers
   logic          valid_ff;
   logic [VW-1:0] out_energy_ff, out_energy_in;
   logic [ses_pkg::STATUS_W-1:0] out_status_ff, out_status_in;
   logic [OW-1:0] out_seg_ff;
   logic [VW-1:0] out_sum_ff;

   // RAM ports
   logic [TW-1:0] top_dec;
   logic [SW-1:0] seg_dec;
   logic          val_we, sum_we;
   logic [VW-1:0] val_rd, sum_rd;

   // exec arithmetic
   logic [VW:0]   sum_add;
   logic          open_seg;
   logic          push_full;
   logic          pop_empty;
   logic [VW-1:0] sum_sub;
   logic [SW+OW-1:0] seg_wide;

   assign top_dec = top_ff - 1'b1;
   assign seg_dec = seg_ff - 1'b1;

   // Lower segments' sums live in RAM; the current one is in sum_ff, so
   // entry zero needs no clearing and an opened segment starts at zero.
   ses_ram #(.WIDTH(VW), .DEPTH(STORE_DEPTH)) u_val_ram (
      .clock      (clock),
      .wr_en      (val_we),
      .wr_addr    (top_ff[AW-1:0]),
      .wr_data    (energy_ff),
      .rd_addr    (top_dec[AW-1:0]),
      .rd_data_ff (val_rd)
   );

   ses_ram #(.WIDTH(VW), .DEPTH(SEGMENT_COUNT)) u_sum_ram (
      .clock      (clock),
      .wr_en      (sum_we),
      .wr_addr    (seg_ff),
      .wr_data    (sum_ff),
      .rd_addr    (seg_dec),
      .rd_data_ff (sum_rd)
   );

   assign sum_add   = {1'b0, sum_ff} + {1'b0, energy_ff};
   assign open_seg  = sum_add > {1'b0, cap_ff};
   assign push_full = (top_ff == TOP_FULL) || (open_seg && (seg_ff == SEG_LAST));
   assign pop_empty = (top_ff == '0);
   assign sum_sub   = sum_ff - val_rd;

   always_comb begin
      top_in        = top_ff;
      seg_in        = seg_ff;
      sum_in        = sum_ff;
      val_we        = 1'b0;
      sum_we        = 1'b0;
      out_energy_in = '0;
      out_status_in = ses_pkg::STAT_DONE;
      if (act_ff == ses_pkg::ACT_PUSH) begin
         if (push_full) begin
            out_status_in = ses_pkg::STAT_PUSH_FULL;
         end else begin
            val_we = cmd.exec;
            top_in = top_ff + 1'b1;
            if (open_seg) begin
               sum_we = cmd.exec;   // park the old segment's sum
               seg_in = seg_ff + 1'b1;
               sum_in = energy_ff;
            end else begin
               sum_in = sum_add[VW-1:0];
            end
         end
      end else begin
         if (pop_empty) begin
            out_status_in = ses_pkg::STAT_POP_EMPTY;
         end else begin
            top_in        = top_dec;
            out_energy_in = val_rd;
            if ((sum_sub == '0) && (seg_ff != '0)) begin
               seg_in = seg_dec;
               sum_in = sum_rd;
            end else begin
               sum_in = sum_sub;
            end
         end
      end
   end

   assign seg_wide = {{OW{1'b0}}, seg_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= ses_pkg::CAP_RESET;
         top_ff   <= '0;
         seg_ff   <= '0;
         sum_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) cap_ff <= csr_wr_data;
         if (cmd.exec) begin
            top_ff <= top_in;
            seg_ff <= seg_in;
            sum_ff <= sum_in;
         end
         valid_ff <= cmd.exec;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff    <= req_action;
         energy_ff <= req_energy_in;
      end
      if (cmd.exec) begin
         out_energy_ff <= out_energy_in;
         out_status_ff <= out_status_in;
         out_seg_ff    <= seg_wide[OW-1:0];
         out_sum_ff    <= sum_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_energy_out    = out_energy_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_segment_now   = out_seg_ff;
   assign rsp_segment_total = out_sum_ff;

   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= TOP_FULL)
      else $error("stack count beyond store depth");

   a_seg_bound: assert property (@(posedge clock) disable iff (reset)
      seg_ff <= SEG_LAST)
      else $error("segment index beyond segment count");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (out_status_ff != ses_pkg::STAT_DONE)) |-> (out_energy_ff == '0))
      else $error("error beat carries a nonzero energy");

   a_beat_one_cycle: assert property (@(posedge clock) disable iff (reset)
      valid_ff |=> !valid_ff)
      else $error("result strobe held for more than one cycle");

endmodule

### rtl/segmented_energy_stack_core.sv
// Top level of the segmented energy stack: controller plus datapath.
// Depends on ses_pkg, ses_ctrl, ses_dpath (and ses_ram below it).
//
// A last-in-first-out store of 10-bit energy values split into segments,
// each keeping a running sum. Raise start with req_action/req_energy_in;
// the request beat is taken on a rising edge with start high and busy low.
// A push (action 0) opens a new zeroed segment when the current sum plus the
// value would exceed the capacity register, then stacks the value and adds it
// to the segment sum. A pop (action 1) returns the top value and subtracts it;
// a segment above 0 whose sum hits zero falls back to the previous segment.
// Pop on an empty store gives status 1, push on a full store (no value slot
// or no segment left to open) gives status 2; neither changes any state.
// Every request produces exactly one result beat: rsp_valid is high for one
// cycle and the receiver cannot stall it, so sample it when it appears.
// Timing: the accepting edge launches the value RAM and segment-sum RAM
// reads (registered read); the execute state that follows does the
// read-modify-write of top count, segment index and current sum and
// registers the result, which is then shown. busy is high in the execute
// state, and the next item can be accepted while the result is shown.
// No clearing pass is needed after reset.
// The capacity register (reset 1000) is written with csr_wr_en/csr_wr_data
// and must only be written while busy is low and no result is pending.
module segmented_energy_stack_core #(
   parameter int STORE_DEPTH   = ses_pkg::STORE_DEPTH_DEF,
   parameter int SEGMENT_COUNT = ses_pkg::SEGMENT_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_action,
   input  logic [ses_pkg::VAL_W-1:0]       req_energy_in,
   // capacity register
   input  logic                            csr_wr_en,
   input  logic [ses_pkg::VAL_W-1:0]       csr_wr_data,
   // result channel, one beat per request
   output logic                            rsp_valid,
   output logic [ses_pkg::VAL_W-1:0]       rsp_energy_out,
   output logic [ses_pkg::STATUS_W-1:0]    rsp_status,
   output logic [ses_pkg::SEG_OUT_W-1:0]   rsp_segment_now,
   output logic [ses_pkg::VAL_W-1:0]       rsp_segment_total
);

   ses_pkg::ctrl_cmd_type cmd;

   // Sequencer: idle -> execute -> idle.
   ses_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // Storage and arithmetic; results registered here.
   ses_dpath #(
      .STORE_DEPTH   (STORE_DEPTH),
      .SEGMENT_COUNT (SEGMENT_COUNT)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_action        (req_action),
      .req_energy_in     (req_energy_in),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_energy_out    (rsp_energy_out),
      .rsp_status        (rsp_status),
      .rsp_segment_now   (rsp_segment_now),
      .rsp_segment_total (rsp_segment_total)
   );

endmodule

### tb/sv/segmented_energy_stack_core_test.sv
// Self-checking bench for segmented_energy_stack_core: a queued request driver,
// a result monitor and a cycle-free predictor of the segmented stack.
// Depends on ses_pkg and the RTL under rtl/.
module segmented_energy_stack_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 10;
   localparam int MAX_GAP      = 13;
   // idle cycles after the last result to catch stray beats
   localparam int TAIL_CYCLES  = 8;
   // ~2200 beats with idle gaps up to MAX_GAP; leave lots of slack
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_PRINTS   = 40;
   localparam int STORE_DEPTH  = ses_pkg::STORE_DEPTH_DEF;
   localparam int SEG_COUNT    = ses_pkg::SEGMENT_COUNT_DEF;

   typedef logic [ses_pkg::VAL_W-1:0] energy_type;

   typedef enum logic [1:0] {
      PLAN_BEAT,        // one request beat
      PLAN_CAP_WRITE,   // capacity write, only once everything is back
      PLAN_DRAIN        // sender holds off until every result has come
   } plan_kind_type;

   typedef struct {
      plan_kind_type kind;
      logic          action;
      energy_type    value;   // energy for a beat, capacity for a write
      int unsigned   gap;     // idle cycles before this entry
   } plan_entry_type;

   typedef struct packed {
      energy_type                    energy;
      logic [ses_pkg::STATUS_W-1:0]  status;
      logic [ses_pkg::SEG_OUT_W-1:0] segment;
      energy_type                    total;
   } stack_result_type;

   // DUT ports, all inputs known from time zero
   logic                          clock         = 1'b0;
   logic                          reset         = 1'b1;
   logic                          start         = 1'b0;
   logic                          busy;
   logic                          req_action    = ses_pkg::ACT_PUSH;
   energy_type                    req_energy_in = '0;
   logic                          csr_wr_en     = 1'b0;
   energy_type                    csr_wr_data   = '0;
   logic                          rsp_valid;
   energy_type                    rsp_energy_out;
   logic [ses_pkg::STATUS_W-1:0]  rsp_status;
   logic [ses_pkg::SEG_OUT_W-1:0] rsp_segment_now;
   energy_type                    rsp_segment_total;

   segmented_energy_stack_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_energy_in     (req_energy_in),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_energy_out    (rsp_energy_out),
      .rsp_status        (rsp_status),
      .rsp_segment_now   (rsp_segment_now),
      .rsp_segment_total (rsp_segment_total)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor state: the stack, one sum per segment, depth and segment.
   // ------------------------------------------------------------------
   energy_type  stack_cap = ses_pkg::CAP_RESET;
   energy_type  stack_vals [STORE_DEPTH];
   energy_type  seg_sums [SEG_COUNT];
   int unsigned stack_depth = 0;
   int unsigned seg_now = 0;

   // Expected result beats, oldest first, and the pending request plan.
   stack_result_type due_beats[$];
   plan_entry_type   request_plan[$];

   // generator side: upper bound on stack depth (rejected pushes ignored)
   int unsigned depth_bound = 0;
   logic        no_idle = 1'b0;

   // driver gap bookkeeping
   logic        armed = 1'b0;
   int unsigned gap_left = 0;

   // statistics and errors
   int unsigned n_errors = 0;
   int unsigned n_checked = 0;
   int unsigned n_pushes = 0;
   int unsigned n_pops = 0;
   int unsigned n_pop_empty = 0;
   int unsigned n_push_full = 0;
   int unsigned n_fallbacks = 0;
   int unsigned n_cap_writes = 0;
   int unsigned n_drains = 0;
   int unsigned cycle_count = 0;

   // One push or pop against the predictor state; returns the result beat.
   function automatic stack_result_type energy_stack_step(logic act, energy_type e);
      stack_result_type r;
      logic             opens;
      r.energy = '0;
      r.status = ses_pkg::STAT_DONE;
      if (act == ses_pkg::ACT_PUSH) begin
         n_pushes++;
         // 11-bit compare so a sum near the top cannot wrap
         opens = ({1'b0, seg_sums[seg_now]} + e) > {1'b0, stack_cap};
         if (stack_depth == STORE_DEPTH || (opens && seg_now == SEG_COUNT - 1)) begin
            // no value slot or no segment left: nothing changes
            r.status = ses_pkg::STAT_PUSH_FULL;
            n_push_full++;
         end else begin
            if (opens) begin
               seg_now++;
               seg_sums[seg_now] = '0;
            end
            stack_vals[stack_depth] = e;
            stack_depth++;
            seg_sums[seg_now] = seg_sums[seg_now] + e;
         end
      end else begin
         n_pops++;
         if (stack_depth == 0) begin
            r.status = ses_pkg::STAT_POP_EMPTY;
            n_pop_empty++;
         end else begin
            stack_depth--;
            r.energy = stack_vals[stack_depth];
            seg_sums[seg_now] = seg_sums[seg_now] - r.energy;
            // an emptied segment above 0 hands back to the one below
            if (seg_sums[seg_now] == '0 && seg_now != 0) begin
               seg_now--;
               n_fallbacks++;
            end
         end
      end
      r.segment = ses_pkg::SEG_OUT_W'(seg_now);
      r.total   = seg_sums[seg_now];
      return r;
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      n_errors++;
      if (n_errors <= MAX_PRINTS)
         $display("[%0t] mismatch on %s: got %0d, want %0d (beat %0d)",
                  $realtime, what, got, want, n_checked);
   endtask

   // ------------------------------------------------------------------
   // Plan builders, run at time zero.
   // ------------------------------------------------------------------
   function automatic int unsigned pick_gap();
      if (no_idle)
         return 0;
      return $urandom_range(0, MAX_GAP);
   endfunction

   function automatic void plan_beat(logic act, energy_type e);
      plan_entry_type p;
      p.kind   = PLAN_BEAT;
      p.action = act;
      p.value  = e;
      p.gap    = pick_gap();
      request_plan.push_back(p);
      if (act == ses_pkg::ACT_PUSH) begin
         if (depth_bound < STORE_DEPTH)
            depth_bound++;
      end else if (depth_bound != 0) begin
         depth_bound--;
      end
   endfunction

   function automatic void plan_hold(plan_kind_type kind, energy_type v);
      plan_entry_type p;
      p.kind   = kind;
      p.action = ses_pkg::ACT_PUSH;
      p.value  = v;
      p.gap    = 0;
      request_plan.push_back(p);
   endfunction

   // pop past the bottom so the stack is surely empty (and empty pops happen)
   function automatic void plan_empty();
      int unsigned n;
      n = depth_bound + 2;
      repeat (n) plan_beat(ses_pkg::ACT_POP, energy_type'($urandom));
   endfunction

   // energy values biased toward the interesting spots around the capacity
   function automatic energy_type pick_energy(energy_type cap);
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 10)
         return '0;
      if (sel < 45)
         return energy_type'($urandom_range(1, 15));
      if (sel < 60)
         return energy_type'($urandom_range(cap / 2, cap));
      if (sel < 65)
         return '1;
      return energy_type'($urandom_range(0, (1 << ses_pkg::VAL_W) - 1));
   endfunction

   // random walk in runs of pushes, pops or a mix, with occasional full drains
   function automatic void plan_walk(int unsigned n_beats, energy_type cap);
      int unsigned done_beats;
      int unsigned run_len;
      int unsigned mode;
      logic        act;
      done_beats = 0;
      while (done_beats < n_beats) begin
         run_len = $urandom_range(1, 40);
         mode    = $urandom_range(0, 9);
         no_idle = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) == 0)
            plan_hold(PLAN_DRAIN, '0);
         repeat (run_len) begin
            if (mode < 2)
               act = 1'($urandom_range(0, 1));
            else
               act = (mode < 7) ? ses_pkg::ACT_PUSH : ses_pkg::ACT_POP;
            plan_beat(act, (act == ses_pkg::ACT_PUSH) ? pick_energy(cap)
                                                       : energy_type'($urandom));
            done_beats++;
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // Driver: one request beat or capacity write at a time, in plan order.
   // start and csr_wr_en each get exactly one NBA per edge.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : drive_beat
      logic start_nxt;
      logic wr_nxt;
      start_nxt = start;
      wr_nxt    = 1'b0;
      if (reset) begin
         start_nxt = 1'b0;
         armed     = 1'b0;
      end else begin
         // beat taken at this edge: predict its result now
         if (start && !busy) begin
            due_beats.push_back(energy_stack_step(req_action, req_energy_in));
            start_nxt = 1'b0;
         end
         if (!start_nxt && request_plan.size() != 0) begin
            if (!armed) begin
               gap_left = request_plan[0].gap;
               armed    = 1'b1;
            end
            if (gap_left != 0) begin
               gap_left--;
            end else begin
               case (request_plan[0].kind)
                  PLAN_BEAT: begin
                     start_nxt = 1'b1;
                     req_action    <= request_plan[0].action;
                     req_energy_in <= request_plan[0].value;
                     void'(request_plan.pop_front());
                     armed = 1'b0;
                  end
                  PLAN_CAP_WRITE: begin
                     // block idle and nothing owed: safe to change capacity
                     if (due_beats.size() == 0 && !busy) begin
                        wr_nxt = 1'b1;
                        csr_wr_data <= request_plan[0].value;
                        stack_cap = request_plan[0].value;
                        n_cap_writes++;
                        void'(request_plan.pop_front());
                        armed = 1'b0;
                     end
                  end
                  default: begin
                     if (due_beats.size() == 0 && !busy) begin
                        n_drains++;
                        void'(request_plan.pop_front());
                        armed = 1'b0;
                     end
                  end
               endcase
            end
         end
      end
      start     <= start_nxt;
      csr_wr_en <= wr_nxt;
   end

   // ------------------------------------------------------------------
   // Monitor: every strobed result is matched against the oldest one due.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_beat
      stack_result_type want;
      if (!reset) begin
         if ($isunknown(rsp_valid)) begin
            report_mismatch("rsp_valid unknown", 0, 0);
         end else if (rsp_valid) begin
            if (due_beats.size() == 0) begin
               report_mismatch("result beat with nothing due", 1, 0);
            end else begin
               want = due_beats.pop_front();
               n_checked++;
               if (rsp_energy_out !== want.energy)
                  report_mismatch("energy_out", rsp_energy_out, want.energy);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_segment_now !== want.segment)
                  report_mismatch("segment_now", rsp_segment_now, want.segment);
               if (rsp_segment_total !== want.total)
                  report_mismatch("segment_total", rsp_segment_total, want.total);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due",
                  CYCLE_LIMIT, due_beats.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus plan and end of run.
   // ------------------------------------------------------------------
   initial begin
      for (int i = 0; i < SEG_COUNT; i++)
         seg_sums[i] = '0;

      // Directed, at the reset capacity of 1000.
      no_idle = 1'b0;
      plan_beat(ses_pkg::ACT_POP, '0);         // pop on empty store
      plan_beat(ses_pkg::ACT_PUSH, '0);        // zero value on segment 0
      plan_beat(ses_pkg::ACT_PUSH, '1);        // value above capacity opens seg 1
      plan_beat(ses_pkg::ACT_PUSH, 10'd1);     // 1023+1 opens seg 2
      no_idle = 1'b1;
      plan_beat(ses_pkg::ACT_PUSH, 10'd999);   // lands exactly on capacity
      plan_beat(ses_pkg::ACT_PUSH, 10'd512);   // opens seg 3
      plan_beat(ses_pkg::ACT_PUSH, '0);
      plan_beat(ses_pkg::ACT_POP, '1);         // energy ignored on pop
      plan_beat(ses_pkg::ACT_POP, '0);         // seg 3 empties, back to seg 2
      plan_beat(ses_pkg::ACT_POP, '0);
      plan_beat(ses_pkg::ACT_POP, '0);         // back to seg 1
      no_idle = 1'b0;
      plan_beat(ses_pkg::ACT_POP, '0);         // back to seg 0
      plan_beat(ses_pkg::ACT_POP, '0);         // seg 0 with zero sum stays put
      plan_beat(ses_pkg::ACT_POP, '0);         // empty again
      plan_beat(ses_pkg::ACT_PUSH, 10'h155);
      plan_beat(ses_pkg::ACT_PUSH, 10'h2aa);   // sums to 1023, opens seg 1
      plan_beat(ses_pkg::ACT_POP, '0);
      plan_beat(ses_pkg::ACT_POP, '0);
      plan_hold(PLAN_DRAIN, '0);

      // Capacity 0: every nonzero push opens a segment until none are left.
      plan_hold(PLAN_CAP_WRITE, '0);
      for (int i = 0; i < SEG_COUNT + 2; i++) begin
         no_idle = (i % 64) < 20;
         if (i == SEG_COUNT / 2)
            plan_hold(PLAN_DRAIN, '0);
         plan_beat(ses_pkg::ACT_PUSH,
                   energy_type'($urandom_range(1, (1 << ses_pkg::VAL_W) - 1)));
      end
      plan_beat(ses_pkg::ACT_PUSH, '0);        // zero on a nonzero sum still opens a segment: full
      plan_empty();

      // Capacity 1023 with tiny values: the value store itself runs out.
      plan_hold(PLAN_CAP_WRITE, '1);
      no_idle = 1'b1;
      for (int i = 0; i < STORE_DEPTH + 4; i++) begin
         if (i == 100)
            no_idle = 1'b0;
         plan_beat(ses_pkg::ACT_PUSH, energy_type'($urandom_range(0, 3)));
      end
      plan_empty();

      // Random walks at capacity 1 and at a few random capacities.
      plan_hold(PLAN_CAP_WRITE, 10'd1);
      plan_walk(200, 10'd1);
      plan_empty();
      repeat (3) begin : random_cap
         energy_type cap;
         cap = energy_type'($urandom_range(2, (1 << ses_pkg::VAL_W) - 2));
         plan_hold(PLAN_CAP_WRITE, cap);
         plan_walk(200, cap);
         plan_empty();
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // negedge: all edge activity of driver and monitor has settled
      do @(negedge clock);
      while (request_plan.size() != 0 || start || due_beats.size() != 0);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("checked %0d result beats: %0d pushes, %0d pops, %0d capacity writes",
               n_checked, n_pushes, n_pops, n_cap_writes);
      $display("corners: %0d empty pops, %0d full pushes, %0d segment fallbacks, %0d drains",
               n_pop_empty, n_push_full, n_fallbacks, n_drains);
      if (n_errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
